// ===== design/nmea_sentence_parser_macros.svh =====
// Assertion macros for the NMEA sentence parser.
// Clock i_clk and active-low reset i_rst_n are taken from the including module.
`ifndef NMEA_SENTENCE_PARSER_MACROS_SVH
`define NMEA_SENTENCE_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NSP_ASSERT_IMP(lbl, ante, cons)
`define NSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/nsp_pkg.sv =====
// Shared types and constants of the NMEA sentence parser.
// No dependencies.
package nsp_pkg;

    localparam int MaxSentenceLen = 128;
    localparam int MaxFields      = 32;

    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChComma  = 8'h2C;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChDot    = 8'h2E;
    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChMinus  = 8'h2D;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChA      = 8'h41;
    localparam logic [7:0] ChS      = 8'h53;
    localparam logic [7:0] ChW      = 8'h57;

    localparam logic [23:0] TypeRmc = 24'h524D43;
    localparam logic [23:0] TypeGga = 24'h474741;

    // accumulator value held when |x| * 1e7 saturates at 2^48-1
    localparam logic [18:0] SatHi  = 19'd281474;
    localparam logic [6:0]  SatLo  = 7'd97;
    localparam logic [29:0] SatRem = 30'd976710655;
    localparam logic [9:0]  SatF3  = 10'd671;

    localparam int FlSign = 0;
    localparam int FlDot  = 1;
    localparam int FlStop = 2;
    localparam int FlNz   = 3;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_STAR    = 3'd1,
        ST_BAD_CHECK  = 3'd2,
        ST_BAD_TYPE   = 3'd3,
        ST_FEW_FIELDS = 3'd4,
        ST_OVERFLOW   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RMC  = 2'd1,
        KIND_GGA  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ROLE_NONE = 3'd0,
        ROLE_TYPE = 3'd1,
        ROLE_TIME = 3'd2,
        ROLE_CHAR = 3'd3,
        ROLE_DEC  = 3'd4,
        ROLE_INT  = 3'd5
    } t_role;

    typedef struct packed {
        logic [18:0] hi;
        logic [6:0]  lo;
        logic [29:0] rem;
        logic [9:0]  f3;
        logic        rnd;
        logic [7:0]  ival;
        logic [7:0]  flags;
    } t_acc;

    typedef struct packed {
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic [9:0] ms;
    } t_tm;

    typedef struct packed {
        logic               valid;
        t_tm                tm;
        logic [31:0]        lat_mag;
        logic               lat_neg;
        logic [31:0]        lon_mag;
        logic               lon_neg;
        logic signed [31:0] speed;
        logic signed [31:0] course;
        logic signed [31:0] alt;
        logic [7:0]         quality;
        logic [7:0]         sats;
    } t_pend;

    typedef struct packed {
        logic               valid;
        logic [30:0]        tpack;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [31:0] speed;
        logic signed [31:0] course;
        logic signed [31:0] alt;
        logic [7:0]         quality;
        logic [7:0]         sats;
    } t_fix;

    typedef struct packed {
        logic [31:0]        coord_mag;
        logic signed [31:0] meas;
        logic [7:0]         ival;
    } t_conv;

endpackage

// ===== design/nmea_sentence_parser.sv =====
// NMEA 0183 RMC/GGA sentence parser, top level; uses nsp_pkg, nsp_accum, nsp_convert.
// Output: a result is registered onto m_axis once the closing byte has passed through the input register.
// Throughput: one byte per cycle; a byte waits in the input register only while
// a result is held unaccepted in the output register.
// Reset: synchronous, clears all parse state and the kept fix to zero; no clearing pass.
`include "nmea_sentence_parser_macros.svh"
module nmea_sentence_parser
    import nsp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // rx_byte[7:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0] fix_valid[3] time_packed[34:4] latitude[66:35] longitude[98:67]
    // speed[130:99] course[162:131] fix_quality[170:163] satellites[178:171]
    // altitude[210:179], zero pad[215:211]
    output logic [215:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser   // sentence_kind[1:0]
);

    localparam logic [5:0] FldType      = 6'd0;
    localparam logic [5:0] FldTime      = 6'd1;
    localparam logic [5:0] FldRmcStatus = 6'd2;
    localparam logic [5:0] FldRmcLat    = 6'd3;
    localparam logic [5:0] FldRmcNs     = 6'd4;
    localparam logic [5:0] FldRmcLon    = 6'd5;
    localparam logic [5:0] FldRmcEw     = 6'd6;
    localparam logic [5:0] FldRmcSpeed  = 6'd7;
    localparam logic [5:0] FldRmcCourse = 6'd8;
    localparam logic [5:0] FldGgaLat    = 6'd2;
    localparam logic [5:0] FldGgaNs     = 6'd3;
    localparam logic [5:0] FldGgaLon    = 6'd4;
    localparam logic [5:0] FldGgaEw     = 6'd5;
    localparam logic [5:0] FldGgaQual   = 6'd6;
    localparam logic [5:0] FldGgaSats   = 6'd7;
    localparam logic [5:0] FldGgaAlt    = 6'd9;
    localparam logic [5:0] MinFieldIdx  = 6'd9;

    function automatic t_kind kind_of(input logic [23:0] t);
        t_kind k;
        k = KIND_NONE;
        if (t == TypeRmc) k = KIND_RMC;
        else if (t == TypeGga) k = KIND_GGA;
        return k;
    endfunction

    function automatic t_role role_of(input logic [5:0] f, input t_kind k);
        t_role r;
        r = ROLE_NONE;
        if (f == FldType) begin
            r = ROLE_TYPE;
        end else if (k == KIND_RMC) begin
            if (f == FldTime) r = ROLE_TIME;
            else if (f == FldRmcStatus || f == FldRmcNs || f == FldRmcEw) r = ROLE_CHAR;
            else if (f == FldRmcLat || f == FldRmcLon || f == FldRmcSpeed || f == FldRmcCourse)
                r = ROLE_DEC;
        end else if (k == KIND_GGA) begin
            if (f == FldTime) r = ROLE_TIME;
            else if (f == FldGgaNs || f == FldGgaEw) r = ROLE_CHAR;
            else if (f == FldGgaLat || f == FldGgaLon || f == FldGgaAlt) r = ROLE_DEC;
            else if (f == FldGgaQual || f == FldGgaSats) r = ROLE_INT;
        end
        return r;
    endfunction

    // {bad, nibble}
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] h;
        if (c >= ChZero && c <= ChNine) h = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            h = {1'b0, 4'(c[3:0] + 4'd9)};
        else h = 5'b10000;
        return h;
    endfunction

    function automatic logic signed [31:0] coord_sat(input logic [31:0] m, input logic neg);
        logic signed [31:0] v;
        if (neg) v = $signed(32'(-m));
        else v = m[31] ? 32'sh7FFF_FFFF : $signed(m);
        return v;
    endfunction

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_status     r_out_status;
    t_kind       r_out_kind;
    logic        r_in_sent;
    logic [7:0]  r_byte_cnt;
    logic [7:0]  r_xor;
    logic [1:0]  r_star;
    logic [7:0]  r_rcheck;
    logic        r_bad_check;
    logic [5:0]  r_field;
    logic [7:0]  r_pos;
    logic [23:0] r_type;
    t_acc        r_acc;
    t_pend       r_pend;
    t_fix        r_kept;

    logic        n_in_sent;
    logic [7:0]  n_byte_cnt;
    logic [7:0]  n_xor;
    logic [1:0]  n_star;
    logic [7:0]  n_rcheck;
    logic        n_bad_check;
    logic [5:0]  n_field;
    logic [7:0]  n_pos;
    logic [23:0] n_type;
    t_acc        n_acc;
    t_pend       n_pend;
    t_fix        n_kept;
    logic        n_produce;
    t_status     n_status;
    t_kind       n_kind;

    logic        advance;
    t_kind       cur_kind;
    t_role       cur_role;
    t_acc        acc_char;
    t_tm         tm_char;
    logic [23:0] type_char;
    t_conv       conv;
    t_pend       fin_pend;
    logic [23:0] fin_type;
    logic        is_rmc;
    logic        is_gga;
    logic [4:0]  hex;
    t_kind       end_kind;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign cur_kind      = kind_of(r_type);
    assign cur_role      = role_of(r_field, cur_kind);
    assign is_rmc        = (cur_kind == KIND_RMC);
    assign is_gga        = (cur_kind == KIND_GGA);
    assign hex           = hex_of(r_in_byte);

    nsp_accum u_accum (
        .i_byte (r_in_byte),
        .i_role (cur_role),
        .i_pos  (r_pos),
        .i_acc  (r_acc),
        .i_tm   (r_pend.tm),
        .i_type (r_type),
        .o_acc  (acc_char),
        .o_tm   (tm_char),
        .o_type (type_char)
    );

    nsp_convert u_convert (
        .i_acc  (r_acc),
        .o_conv (conv)
    );

    always_comb begin
        fin_pend = r_pend;
        fin_type = r_type;
        unique case (cur_role)
            ROLE_TYPE: if (r_pos != 8'd5) fin_type = '0;
            ROLE_TIME: if (r_pos < 8'd6) fin_pend.tm = '0;
            ROLE_CHAR: begin
                if (is_rmc && r_field == FldRmcStatus) begin
                    fin_pend.valid = r_acc.flags[0];
                end else if (r_acc.flags[1]) begin
                    if ((is_rmc && r_field == FldRmcNs) || (is_gga && r_field == FldGgaNs))
                        fin_pend.lat_neg = !r_pend.lat_neg;
                    else
                        fin_pend.lon_neg = !r_pend.lon_neg;
                end
            end
            ROLE_DEC: begin
                if ((is_rmc && r_field == FldRmcLat) || (is_gga && r_field == FldGgaLat)) begin
                    fin_pend.lat_mag = conv.coord_mag;
                    fin_pend.lat_neg = r_acc.flags[FlSign];
                end else if ((is_rmc && r_field == FldRmcLon) ||
                             (is_gga && r_field == FldGgaLon)) begin
                    fin_pend.lon_mag = conv.coord_mag;
                    fin_pend.lon_neg = r_acc.flags[FlSign];
                end else if (is_gga) begin
                    fin_pend.alt = conv.meas;
                end else if (r_field == FldRmcSpeed) begin
                    fin_pend.speed = conv.meas;
                end else begin
                    fin_pend.course = conv.meas;
                end
            end
            ROLE_INT: begin
                if (r_field == FldGgaQual) begin
                    fin_pend.quality = conv.ival;
                    fin_pend.valid   = r_acc.flags[FlNz];
                end else begin
                    fin_pend.sats = conv.ival;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_in_sent   = r_in_sent;
        n_byte_cnt  = r_byte_cnt;
        n_xor       = r_xor;
        n_star      = r_star;
        n_rcheck    = r_rcheck;
        n_bad_check = r_bad_check;
        n_field     = r_field;
        n_pos       = r_pos;
        n_type      = r_type;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_kept      = r_kept;
        n_produce   = 1'b0;
        n_status    = ST_OK;
        n_kind      = KIND_NONE;
        end_kind    = kind_of((r_star == 2'd0) ? fin_type : r_type);
        if (advance) begin
            priority if (r_in_byte == ChDollar) begin
                n_in_sent   = 1'b1;
                n_byte_cnt  = 8'd1;
                n_xor       = '0;
                n_star      = '0;
                n_rcheck    = '0;
                n_bad_check = 1'b0;
                n_field     = '0;
                n_pos       = '0;
                n_type      = '0;
                n_acc       = '0;
                n_pend      = '0;
            end else if (!r_in_sent) begin
                n_in_sent = 1'b0;
            end else if (r_in_byte == ChCr || r_in_byte == ChLf) begin
                if (r_star == 2'd0) begin
                    n_pend = fin_pend;
                    n_type = fin_type;
                end
                n_in_sent  = 1'b0;
                n_byte_cnt = '0;
                n_produce  = 1'b1;
                n_kind     = end_kind;
                priority if (r_star == 2'd0) n_status = ST_NO_STAR;
                else if (r_star != 2'd3 || r_bad_check || r_rcheck != r_xor)
                    n_status = ST_BAD_CHECK;
                else if (end_kind == KIND_NONE) n_status = ST_BAD_TYPE;
                else if (r_field < MinFieldIdx) n_status = ST_FEW_FIELDS;
                else n_status = ST_OK;
                if (n_status == ST_OK) begin
                    n_kept.valid = r_pend.valid;
                    n_kept.tpack = {r_pend.tm.hour, r_pend.tm.minute, r_pend.tm.second,
                                    r_pend.tm.ms};
                    n_kept.lat   = coord_sat(r_pend.lat_mag, r_pend.lat_neg);
                    n_kept.lon   = coord_sat(r_pend.lon_mag, r_pend.lon_neg);
                    if (end_kind == KIND_RMC) begin
                        n_kept.speed  = r_pend.speed;
                        n_kept.course = r_pend.course;
                    end else begin
                        n_kept.quality = r_pend.quality;
                        n_kept.sats    = r_pend.sats;
                        n_kept.alt     = r_pend.alt;
                    end
                end
            end else if (r_byte_cnt >= 8'(MaxSentenceLen - 1)) begin
                n_in_sent  = 1'b0;
                n_byte_cnt = '0;
                n_produce  = 1'b1;
                n_status   = ST_OVERFLOW;
                n_kind     = KIND_NONE;
            end else begin
                n_byte_cnt = 8'(r_byte_cnt + 8'd1);
                if (r_star == 2'd0) begin
                    if (r_in_byte == ChStar) begin
                        n_pend = fin_pend;
                        n_type = fin_type;
                        n_star = 2'd1;
                    end else begin
                        n_xor = r_xor ^ r_in_byte;
                        if (r_in_byte == ChComma && r_field < 6'(MaxFields - 1)) begin
                            n_pend  = fin_pend;
                            n_type  = fin_type;
                            n_field = 6'(r_field + 6'd1);
                            n_pos   = '0;
                            n_acc   = '0;
                        end else begin
                            n_acc     = acc_char;
                            n_pend.tm = tm_char;
                            n_type    = type_char;
                            if (r_pos != 8'hFF) n_pos = 8'(r_pos + 8'd1);
                        end
                    end
                end else if (r_star != 2'd3) begin
                    if (hex[4]) n_bad_check = 1'b1;
                    n_rcheck = {r_rcheck[3:0], hex[3:0]};
                    n_star   = 2'(r_star + 2'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_sent   <= 1'b0;
            r_byte_cnt  <= '0;
            r_xor       <= '0;
            r_star      <= '0;
            r_rcheck    <= '0;
            r_bad_check <= 1'b0;
            r_field     <= '0;
            r_pos       <= '0;
            r_type      <= '0;
            r_acc       <= '0;
            r_pend      <= '0;
            r_kept      <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (n_produce) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_in_sent   <= n_in_sent;
            r_byte_cnt  <= n_byte_cnt;
            r_xor       <= n_xor;
            r_star      <= n_star;
            r_rcheck    <= n_rcheck;
            r_bad_check <= n_bad_check;
            r_field     <= n_field;
            r_pos       <= n_pos;
            r_type      <= n_type;
            r_acc       <= n_acc;
            r_pend      <= n_pend;
            r_kept      <= n_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in_byte <= s_axis_tdata;
        if (n_produce) begin
            r_out_status <= n_status;
            r_out_kind   <= n_kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {5'b0, r_kept.alt, r_kept.sats, r_kept.quality, r_kept.course,
                            r_kept.speed, r_kept.lon, r_kept.lat, r_kept.tpack, r_kept.valid,
                            r_out_status};

    `NSP_ASSERT_NEXT(a_kept_hold, r_out_valid && !m_axis_tready, $stable(r_kept))
    `NSP_ASSERT_IMP(a_idle_count, !r_in_sent, r_byte_cnt == 8'd0)
    `NSP_ASSERT_IMP(a_count_range, r_in_sent,
                    r_byte_cnt != 8'd0 && r_byte_cnt < 8'(MaxSentenceLen))
    `NSP_ASSERT_IMP(a_overflow_kind, r_out_valid && r_out_status == ST_OVERFLOW,
                    r_out_kind == KIND_NONE)

endmodule

// ===== design/nsp_accum.sv =====
// Per-byte update: type and flag letters, time digits, decimal and integer accumulators.
// Depends on nsp_pkg.
module nsp_accum
    import nsp_pkg::*;
(
    input  logic [7:0]  i_byte,
    input  t_role       i_role,
    input  logic [7:0]  i_pos,
    input  t_acc        i_acc,
    input  t_tm         i_tm,
    input  logic [23:0] i_type,
    output t_acc        o_acc,
    output t_tm         o_tm,
    output logic [23:0] o_type
);

    logic        is_dig;
    logic [3:0]  dig;
    logic [6:0]  comp;
    logic [6:0]  comp_n;
    logic [9:0]  ms_w;
    logic [9:0]  n10;
    logic [15:0] prod41;
    logic [3:0]  q;
    logic [9:0]  lnew10;
    logic [22:0] hinew;
    logic [2:0]  frac;
    logic [29:0] frac_w;
    logic [29:0] remn;
    logic [9:0]  f3_w;

    assign is_dig = (i_byte >= ChZero) && (i_byte <= ChNine);
    assign dig    = i_byte[3:0];
    assign frac   = i_acc.flags[5:3];

    always_comb begin
        unique case (i_pos[2:1])
            2'd0:    comp = i_tm.hour;
            2'd1:    comp = i_tm.minute;
            default: comp = i_tm.second;
        endcase
        if (i_pos[0] == 1'b0) begin
            comp_n = is_dig ? {3'b0, dig} : 7'd0;
        end else if (i_acc.flags[0] && is_dig) begin
            comp_n = 7'(comp * 7'd10 + {3'b0, dig});
        end else begin
            comp_n = comp;
        end
        priority if (i_pos == 8'd7) ms_w = 10'd100;
        else if (i_pos == 8'd8) ms_w = 10'd10;
        else ms_w = 10'd1;

        n10    = 10'({3'b0, i_acc.lo} * 10'd10 + {6'b0, dig});
        prod41 = 16'({6'b0, n10} * 16'd41);
        q      = prod41[15:12];
        lnew10 = 10'(n10 - 10'({6'b0, q} * 10'd100));
        hinew  = 23'({4'b0, i_acc.hi} * 23'd10) + {19'b0, q};

        unique case (frac)
            3'd0:    frac_w = 30'd1000000;
            3'd1:    frac_w = 30'd100000;
            3'd2:    frac_w = 30'd10000;
            3'd3:    frac_w = 30'd1000;
            3'd4:    frac_w = 30'd100;
            3'd5:    frac_w = 30'd10;
            default: frac_w = 30'd1;
        endcase
        remn = 30'(i_acc.rem + 30'({26'b0, dig} * frac_w));
        unique case (frac)
            3'd0:    f3_w = 10'd100;
            3'd1:    f3_w = 10'd10;
            3'd2:    f3_w = 10'd1;
            default: f3_w = 10'd0;
        endcase
    end

    always_comb begin
        o_acc  = i_acc;
        o_tm   = i_tm;
        o_type = i_type;
        unique case (i_role)
            ROLE_TYPE: o_type = {i_type[15:0], i_byte};
            ROLE_TIME: begin
                if (i_pos < 8'd6) begin
                    if (i_pos[0] == 1'b0) o_acc.flags[0] = is_dig;
                    unique case (i_pos[2:1])
                        2'd0:    o_tm.hour   = comp_n;
                        2'd1:    o_tm.minute = comp_n;
                        default: o_tm.second = comp_n;
                    endcase
                end else if (i_pos == 8'd6) begin
                    if (i_byte == ChDot) o_acc.flags[1] = 1'b1;
                end else if (i_pos <= 8'd9) begin
                    if (i_acc.flags[1] && !i_acc.flags[2] && is_dig) begin
                        o_tm.ms = 10'(i_tm.ms + 10'({6'b0, dig} * ms_w));
                    end else begin
                        o_acc.flags[2] = 1'b1;
                    end
                end
            end
            ROLE_CHAR: begin
                if (i_pos == 8'd0) begin
                    if (i_byte == ChA) o_acc.flags[0] = 1'b1;
                    if (i_byte == ChS || i_byte == ChW) o_acc.flags[1] = 1'b1;
                end
            end
            ROLE_DEC: begin
                if (!i_acc.flags[FlStop]) begin
                    priority if (i_pos == 8'd0 && (i_byte == ChMinus || i_byte == ChPlus)) begin
                        if (i_byte == ChMinus) o_acc.flags[FlSign] = 1'b1;
                    end else if (is_dig) begin
                        if (!i_acc.flags[FlDot]) begin
                            if (hinew > {4'b0, SatHi} ||
                                (hinew == {4'b0, SatHi} && lnew10[6:0] >= 7'd98)) begin
                                o_acc.hi  = SatHi;
                                o_acc.lo  = SatLo;
                                o_acc.rem = SatRem;
                                o_acc.f3  = SatF3;
                                o_acc.rnd = 1'b0;
                            end else begin
                                o_acc.hi  = hinew[18:0];
                                o_acc.lo  = lnew10[6:0];
                                o_acc.rem = 30'({23'b0, lnew10[6:0]} * 30'd10000000);
                            end
                        end else if (frac < 3'd7) begin
                            o_acc.flags[5:3] = 3'(frac + 3'd1);
                            if (i_acc.hi == SatHi && remn > SatRem) begin
                                o_acc.rem = SatRem;
                                o_acc.f3  = SatF3;
                                o_acc.rnd = 1'b0;
                            end else begin
                                o_acc.rem = remn;
                                o_acc.f3  = 10'(i_acc.f3 + 10'({6'b0, dig} * f3_w));
                                if (frac == 3'd3) o_acc.rnd = (dig >= 4'd5);
                            end
                        end
                    end else if (i_byte == ChDot && !i_acc.flags[FlDot]) begin
                        o_acc.flags[FlDot] = 1'b1;
                    end else begin
                        o_acc.flags[FlStop] = 1'b1;
                    end
                end
            end
            ROLE_INT: begin
                if (!i_acc.flags[FlStop]) begin
                    priority if (i_pos == 8'd0 && (i_byte == ChMinus || i_byte == ChPlus)) begin
                        if (i_byte == ChMinus) o_acc.flags[FlSign] = 1'b1;
                    end else if (is_dig) begin
                        o_acc.ival = 8'(i_acc.ival * 8'd10 + {4'b0, dig});
                        if (dig != 4'd0) o_acc.flags[FlNz] = 1'b1;
                    end else begin
                        o_acc.flags[FlStop] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/nsp_convert.sv =====
// Field close conversion: ddmm.mmmm to 1e-7 degree, 0.001 units with rounding, signed integers.
// Depends on nsp_pkg.
module nsp_convert
    import nsp_pkg::*;
(
    input  t_acc  i_acc,
    output t_conv o_conv
);

    logic [29:0] z;
    logic [60:0] prod;
    logic [43:0] base;
    logic [43:0] csum;
    logic [35:0] mag;
    logic        neg;

    assign neg  = i_acc.flags[FlSign];
    assign z    = i_acc.rem + 30'd30;
    assign prod = 61'({31'b0, z} * 61'd1145324613);
    assign base = 44'({25'b0, i_acc.hi} * 44'd10000000);
    assign csum = base + {19'b0, prod[60:36]};
    assign mag  = 36'({17'b0, i_acc.hi} * 36'd100000) + 36'({29'b0, i_acc.lo} * 36'd1000)
                + {26'b0, i_acc.f3} + {35'b0, i_acc.rnd};

    always_comb begin
        o_conv.coord_mag = (csum > 44'h0_8000_0000) ? 32'h8000_0000 : csum[31:0];
        if (!neg) begin
            o_conv.meas = (mag > 36'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
        end else begin
            o_conv.meas = (mag > 36'h0_8000_0000) ? 32'sh8000_0000 : $signed(32'(-mag[31:0]));
        end
        o_conv.ival = neg ? 8'(8'd0 - i_acc.ival) : i_acc.ival;
    end

endmodule
